/* hw/rtl/vpr_pkg.sv */
`default_nettype none
package vpr_pkg;

  localparam int NUM_CHANNELS_DEF    = 1024;
  localparam int COEF_FRAC_BITS_DEF  = 17;
  localparam int PHASOR_BITS_DEF     = 18;

  localparam int COORD_W     = 32;
  localparam int SAMPLE_W    = 24;
  localparam int CHANNEL_W   = 10;
  localparam int PHASE_W     = 56;
  localparam int FACTOR_W    = 32;
  localparam int FACTOR_FRAC = 28;
  localparam int ANGLE_W     = 32;
  localparam int HALF_W      = 28;
  localparam int PROD_W      = 88;
  localparam int CORDIC_W    = 34;
  localparam int CORDIC_FRAC = 30;
  localparam int MAX_CELLS   = 24;
  localparam int NUM_COEF    = 12;

  // The millimetre-to-metre divisor 1000 is 125 times 8; the 8 joins the power-of-two shift.
  localparam int DIV_ODD     = 125;
  localparam int DIV_ODD_SH  = 3;
  localparam int REM_W       = 7;
  localparam int DIGIT_W     = 16;
  localparam int RECIP_SH    = 30;
  // ceil(2^30 / 125); exact quotient for every dividend below 125 * 2^16.
  localparam logic [DIGIT_W+REM_W:0] RECIP_ODD = 24'd8589935;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] EIGHTH_TURN  = 34'sd536870912;
  localparam logic [ANGLE_W-1:0]         ANGLE_OFFSET = 32'h2000_0000;

  typedef enum logic [1:0] {
    OP_BASELINE    = 2'd0,
    OP_SAMPLE      = 2'd1,
    OP_LOAD_COEF   = 2'd2,
    OP_LOAD_FACTOR = 2'd3
  } op_t;

  localparam logic KIND_UVW = 1'b0;
  localparam logic KIND_VIS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_BOUT,
    S_FETCH,
    S_MLO,
    S_MHI,
    S_MSUM,
    S_DIV,
    S_ANG,
    S_CHAIN,
    S_CMUL,
    S_CSUM,
    S_SOUT
  } state_t;

  typedef struct packed {
    logic                       vld;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cord_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic signed [CORDIC_W-1:0] atan_turns(input int idx);
    logic signed [CORDIC_W-1:0] r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/vpr_cordic_cell.sv */
`default_nettype none
module vpr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vpr_pkg::cord_t cin,
  output vpr_pkg::cord_t cout
);
  import vpr_pkg::*;

  localparam logic signed [CORDIC_W-1:0] ATAN = atan_turns(IDX);

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  assign dx = $signed(cin.y) >>> IDX;
  assign dy = $signed(cin.x) >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.vld <= 1'b0;
    end else begin
      cout.vld <= cin.vld;
    end
    if (!cin.z[CORDIC_W-1]) begin
      cout.x <= cin.x - dx;
      cout.y <= cin.y + dy;
      cout.z <= cin.z - ATAN;
    end else begin
      cout.x <= cin.x + dx;
      cout.y <= cin.y - dy;
      cout.z <= cin.z + ATAN;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vpr_phase_div.sv */
`default_nettype none
module vpr_phase_div #(
  parameter int MW = 88,
  parameter int SH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MW-1:0]               dividend,
  output logic                        done,
  output logic [vpr_pkg::ANGLE_W-1:0] quo
);
  import vpr_pkg::*;

  localparam int SW    = MW + 1;
  localparam int TW    = SW - SH;
  localparam int NL    = (TW + DIGIT_W - 1) / DIGIT_W;
  localparam int RW    = NL * DIGIT_W;
  localparam int CNT_W = $clog2(NL + 1);
  localparam int CUR_W = REM_W + DIGIT_W;
  localparam int QM_W  = CUR_W + DIGIT_W + REM_W + 1;

  localparam logic [SW-1:0] HALF_D = SW'(DIV_ODD) << (SH - 1);

  logic [SW-1:0]      rsum;
  logic [RW-1:0]      t_r;
  logic [REM_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt;
  logic [CUR_W-1:0]   cur;
  logic [QM_W-1:0]    qmul;
  logic [DIGIT_W-1:0] qd;
  logic [CUR_W-1:0]   qprod;
  logic [CUR_W-1:0]   rnext;

  // Adding half the divisor first turns the floor quotient into the rounded one.
  assign rsum  = SW'(dividend) + HALF_D;
  assign cur   = {rem_r, t_r[RW-1 -: DIGIT_W]};
  assign qmul  = QM_W'(cur) * QM_W'(RECIP_ODD);
  assign qd    = qmul[RECIP_SH +: DIGIT_W];
  assign qprod = CUR_W'(qd) * CUR_W'(DIV_ODD);
  assign rnext = cur - qprod;

  // Long division by 125, one 16-bit digit per cycle from the top; the power-of-two
  // part of the divisor is a plain shift. Only the low quotient digits are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(NL);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
    if (start) begin
      t_r   <= RW'(rsum >> SH);
      rem_r <= '0;
      quo   <= '0;
    end else if (cnt != '0) begin
      t_r   <= t_r << DIGIT_W;
      rem_r <= rnext[REM_W-1:0];
      quo   <= {quo[ANGLE_W-DIGIT_W-1:0], qd};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/visibility_phase_rotator_top.sv */
`default_nettype none
// Visibility phase rotator. Loads (coefficient, channel factor) are written as they are accepted.
// In a baseline beat the twelve matrix and phase-vector products run through one
// multiplier, one product a cycle. In a sample beat the 88-bit product of phase and factor
// is divided by a constant, one 16-bit quotient digit a cycle through a reciprocal
// multiply (five digits at the defaults), then the angle walks a chain of PHASOR_BITS
// CORDIC cells (at most 24), then the complex products are registered, summed and rounded.
// One beat is worked at a time; a new beat is taken while the previous result still
// waits in the output register.
// Reading a coefficient or channel factor that was never loaded gives an undefined result.
module visibility_phase_rotator_top #(
  parameter int NUM_CHANNELS   = vpr_pkg::NUM_CHANNELS_DEF,
  parameter int COEF_FRAC_BITS = vpr_pkg::COEF_FRAC_BITS_DEF,
  parameter int PHASOR_BITS    = vpr_pkg::PHASOR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          op,
  input  logic signed [vpr_pkg::COORD_W-1:0]  u_in,
  input  logic signed [vpr_pkg::COORD_W-1:0]  v_in,
  input  logic signed [vpr_pkg::COORD_W-1:0]  w_in,
  input  logic [vpr_pkg::CHANNEL_W-1:0]       channel,
  input  logic signed [vpr_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [vpr_pkg::SAMPLE_W-1:0] sample_im,
  input  logic [3:0]                          coef_index,
  input  logic signed [31:0]                  load_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                kind,
  output logic signed [vpr_pkg::COORD_W-1:0]  u_out,
  output logic signed [vpr_pkg::COORD_W-1:0]  v_out,
  output logic signed [vpr_pkg::COORD_W-1:0]  w_out,
  output logic signed [vpr_pkg::SAMPLE_W-1:0] out_re,
  output logic signed [vpr_pkg::SAMPLE_W-1:0] out_im
);
  import vpr_pkg::*;

  localparam int CW      = (COEF_FRAC_BITS + 3 > 31) ? 31 : COEF_FRAC_BITS + 3;
  localparam int PROD_CW = CW + COORD_W;
  localparam int ACC_W   = CW + COORD_W + 2;
  localparam int EW      = (ACC_W > PHASE_W) ? ACC_W : PHASE_W;
  localparam int DIV_SH  = COEF_FRAC_BITS + FACTOR_FRAC - ANGLE_W + DIV_ODD_SH;
  localparam int NC      = (PHASOR_BITS < MAX_CELLS) ? PHASOR_BITS : MAX_CELLS;
  localparam int SR      = CORDIC_FRAC - (PHASOR_BITS - 2);
  localparam int CPX_W   = SAMPLE_W + PHASOR_BITS;
  localparam int SUM_W   = CPX_W + 1;
  localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic signed [ACC_W-1:0]    HALF_C = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [CORDIC_W-1:0] HALF_X = CORDIC_W'(1) << (SR - 1);
  localparam logic signed [CORDIC_W-1:0] LIM_X  =
    (CORDIC_W'(1) << (PHASOR_BITS - 1)) - CORDIC_W'(1);
  localparam logic signed [SUM_W-1:0]    HALF_S = SUM_W'(1) << (PHASOR_BITS - 3);

  state_t state, state_next;

  logic in_acc;
  logic out_load;
  logic div_start;
  logic chain_start;

  // Stores
  logic signed [CW-1:0]       coef [NUM_COEF];
  logic signed [FACTOR_W-1:0] fmem [NUM_CHANNELS];
  logic signed [FACTOR_W-1:0] fac_q;
  logic signed [PHASE_W-1:0]  bphase;

  // Captured beat
  logic signed [COORD_W-1:0]  u_r, v_r, w_r;
  logic signed [SAMPLE_W-1:0] sr_r, si_r;
  logic [CHANNEL_W-1:0]       chan_r;
  logic                       chan_ok_r;
  logic                       chan_ok;

  // Matrix pipeline
  logic                       iss, p_vld, a_vld;
  logic [1:0]                 row, col, p_row, p_col, a_row;
  logic [3:0]                 cidx;
  logic signed [COORD_W-1:0]  coord_sel;
  logic signed [PROD_CW-1:0]  prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [ACC_W-1:0]    rsh;
  logic signed [COORD_W-1:0]  rsat;
  logic signed [EW-1:0]       pext;
  logic signed [PHASE_W-1:0]  psat;
  logic signed [COORD_W-1:0]  uvw_res [3];

  // Phase path
  logic signed [FACTOR_W-1:0] fac;
  logic                       neg, neg_r;
  logic [PHASE_W-1:0]         pa;
  logic [FACTOR_W-1:0]        fm;
  logic [HALF_W+FACTOR_W-1:0] mlo, mhi;
  logic [PROD_W-1:0]          dividend;
  logic                       div_done;
  logic [ANGLE_W-1:0]         quo;
  logic [ANGLE_W-1:0]         angu, angle, ang_r, ang_sh;
  logic [1:0]                 quad_r;

  // CORDIC and complex multiply
  cord_t                       chain [NC+1];
  logic signed [CORDIC_W-1:0]  xr, yr, cc, ss, pcw, psw;
  logic signed [PHASOR_BITS-1:0] pc_r, ps_r;
  logic signed [CPX_W-1:0]     pr1, pr2, pr3, pr4;
  logic signed [SUM_W-1:0]     re_r, im_r, re_rs, im_rs;
  logic signed [SAMPLE_W-1:0]  re_sat, im_sat;

  assign in_acc  = in_valid && in_ready;
  assign chan_ok = 32'(channel) < 32'(NUM_CHANNELS);

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    div_start   = 1'b0;
    chain_start = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op == OP_BASELINE) begin
            state_next = S_MAC;
          end else if (op == OP_SAMPLE) begin
            state_next = S_FETCH;
          end
        end
      end
      S_MAC: begin
        if (a_vld && a_row == 2'd3) begin
          state_next = S_BOUT;
        end
      end
      S_BOUT, S_SOUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FETCH: state_next = S_MLO;
      S_MLO:   state_next = S_MHI;
      S_MHI:   state_next = S_MSUM;
      S_MSUM: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_ANG;
        end
      end
      S_ANG: begin
        chain_start = 1'b1;
        state_next  = S_CHAIN;
      end
      S_CHAIN: begin
        if (chain[NC].vld) begin
          state_next = S_CMUL;
        end
      end
      S_CMUL: state_next = S_CSUM;
      S_CSUM: state_next = S_SOUT;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- loads and capture ----------------
  always_ff @(posedge clk) begin
    if (in_acc && op == OP_LOAD_COEF && coef_index < 4'(NUM_COEF)) begin
      coef[coef_index] <= load_value[CW-1:0];
    end
    if (in_acc && op == OP_LOAD_FACTOR && chan_ok) begin
      fmem[AW'(channel)] <= load_value;
    end
    fac_q <= fmem[AW'(chan_r)];
    if (in_acc) begin
      u_r       <= u_in;
      v_r       <= v_in;
      w_r       <= w_in;
      sr_r      <= sample_re;
      si_r      <= sample_im;
      chan_r    <= channel;
      chan_ok_r <= chan_ok;
    end
  end

  // ---------------- matrix and phase vector ----------------
  assign cidx = 4'({row, 1'b0}) + 4'(row) + 4'(col);

  always_comb begin
    case (col)
      2'd0:    coord_sel = u_r;
      2'd1:    coord_sel = v_r;
      default: coord_sel = w_r;
    endcase
  end

  assign rsum = acc + HALF_C;
  assign rsh  = rsum >>> COEF_FRAC_BITS;
  assign pext = EW'(acc);

  always_comb begin
    if ((&rsh[ACC_W-1:COORD_W-1]) || !(|rsh[ACC_W-1:COORD_W-1])) begin
      rsat = rsh[COORD_W-1:0];
    end else begin
      rsat = rsh[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    if ((&pext[EW-1:PHASE_W-1]) || !(|pext[EW-1:PHASE_W-1])) begin
      psat = pext[PHASE_W-1:0];
    end else begin
      psat = pext[EW-1] ? {1'b1, {(PHASE_W-1){1'b0}}} : {1'b0, {(PHASE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= 1'b0;
      p_vld  <= 1'b0;
      a_vld  <= 1'b0;
      row    <= '0;
      col    <= '0;
      bphase <= '0;
    end else begin
      if (in_acc && op == OP_BASELINE) begin
        iss <= 1'b1;
        row <= '0;
        col <= '0;
      end else if (iss) begin
        if (col == 2'd2) begin
          col <= '0;
          row <= row + 2'd1;
          if (row == 2'd3) begin
            iss <= 1'b0;
          end
        end else begin
          col <= col + 2'd1;
        end
      end
      p_vld <= iss;
      a_vld <= p_vld && p_col == 2'd2;
      if (a_vld && a_row == 2'd3) begin
        bphase <= psat;
      end
    end
    p_row <= row;
    p_col <= col;
    prod  <= coef[cidx] * coord_sel;
    if (p_vld) begin
      a_row <= p_row;
      if (p_col == 2'd0) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (a_vld && a_row != 2'd3) begin
      uvw_res[a_row] <= rsat;
    end
  end

  // ---------------- phase angle ----------------
  assign fac      = chan_ok_r ? fac_q : '0;
  assign neg      = bphase[PHASE_W-1] ^ fac[FACTOR_W-1];
  assign pa       = bphase[PHASE_W-1] ? (~bphase + PHASE_W'(1)) : bphase;
  assign fm       = fac[FACTOR_W-1] ? (~fac + FACTOR_W'(1)) : fac;
  assign dividend = PROD_W'(mlo) + (PROD_W'(mhi) << HALF_W);
  assign angu     = quo;
  assign angle    = neg_r ? (~angu + ANGLE_W'(1)) : angu;
  assign ang_sh   = ang_r + ANGLE_OFFSET;

  always_ff @(posedge clk) begin
    if (state == S_MLO) begin
      mlo   <= pa[HALF_W-1:0] * fm;
      neg_r <= neg;
    end
    if (state == S_MHI) begin
      mhi <= pa[PHASE_W-1:HALF_W] * fm;
    end
    if (state == S_DIV && div_done) begin
      ang_r <= angle;
    end
    if (state == S_ANG) begin
      quad_r <= ang_sh[ANGLE_W-1:ANGLE_W-2];
    end
  end

  vpr_phase_div #(
    .MW (PROD_W),
    .SH (DIV_SH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .done     (div_done),
    .quo      (quo)
  );

  // ---------------- CORDIC cell chain ----------------
  always_comb begin
    chain[0].vld = chain_start;
    chain[0].x   = CORDIC_GAIN;
    chain[0].y   = '0;
    chain[0].z   = $signed(CORDIC_W'(ang_sh[ANGLE_W-3:0])) - EIGHTH_TURN;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    vpr_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cin  (chain[i]),
      .cout (chain[i+1])
    );
  end

  assign xr = ($signed(chain[NC].x) + HALF_X) >>> SR;
  assign yr = ($signed(chain[NC].y) + HALF_X) >>> SR;

  always_comb begin
    if (xr > LIM_X) begin
      cc = LIM_X;
    end else if (xr < -LIM_X) begin
      cc = -LIM_X;
    end else begin
      cc = xr;
    end
    if (yr > LIM_X) begin
      ss = LIM_X;
    end else if (yr < -LIM_X) begin
      ss = -LIM_X;
    end else begin
      ss = yr;
    end
    case (quad_r)
      2'd0: begin
        pcw = cc;
        psw = ss;
      end
      2'd1: begin
        pcw = -ss;
        psw = cc;
      end
      2'd2: begin
        pcw = -cc;
        psw = -ss;
      end
      default: begin
        pcw = ss;
        psw = -cc;
      end
    endcase
  end

  // ---------------- complex multiply ----------------
  always_ff @(posedge clk) begin
    if (state == S_CHAIN && chain[NC].vld) begin
      pc_r <= pcw[PHASOR_BITS-1:0];
      ps_r <= psw[PHASOR_BITS-1:0];
    end
    if (state == S_CMUL) begin
      pr1 <= sr_r * pc_r;
      pr2 <= si_r * ps_r;
      pr3 <= sr_r * ps_r;
      pr4 <= si_r * pc_r;
    end
    if (state == S_CSUM) begin
      re_r <= SUM_W'(pr1) - SUM_W'(pr2);
      im_r <= SUM_W'(pr3) + SUM_W'(pr4);
    end
  end

  assign re_rs = (re_r + HALF_S) >>> (PHASOR_BITS - 2);
  assign im_rs = (im_r + HALF_S) >>> (PHASOR_BITS - 2);

  always_comb begin
    if ((&re_rs[SUM_W-1:SAMPLE_W-1]) || !(|re_rs[SUM_W-1:SAMPLE_W-1])) begin
      re_sat = re_rs[SAMPLE_W-1:0];
    end else begin
      re_sat = re_rs[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    if ((&im_rs[SUM_W-1:SAMPLE_W-1]) || !(|im_rs[SUM_W-1:SAMPLE_W-1])) begin
      im_sat = im_rs[SAMPLE_W-1:0];
    end else begin
      im_sat = im_rs[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      if (state == S_BOUT) begin
        kind   <= KIND_UVW;
        u_out  <= uvw_res[0];
        v_out  <= uvw_res[1];
        w_out  <= uvw_res[2];
        out_re <= '0;
        out_im <= '0;
      end else begin
        kind   <= KIND_VIS;
        u_out  <= '0;
        v_out  <= '0;
        w_out  <= '0;
        out_re <= re_sat;
        out_im <= im_sat;
      end
    end
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
module tb_top;
  import vpr_pkg::*;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  PHASE_ITEMS = 150;
  localparam int  DRAIN_CYCLES = 200;
  localparam longint FACTOR_DIV = 1000 * (1 << 13);

  typedef struct {
    op_t                op;
    logic signed [31:0] u, v, w;
    logic [9:0]         ch;
    logic signed [23:0] re, im;
    logic [3:0]         idx;
    logic signed [31:0] val;
  } beat_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] u, v, w;
    logic signed [23:0] re, im;
  } result_t;

  class rotator_scoreboard;
    logic signed [19:0] coefs[12];
    logic signed [31:0] factors[1024];
    logic signed [55:0] bl_phase;
    result_t            pending_results[$];
    int                 errors;

    function new();
      bl_phase = '0;
      errors   = 0;
      foreach (coefs[i]) coefs[i] = '0;
      foreach (factors[i]) factors[i] = '0;
    endfunction

    function longint sat(longint x, int w);
      longint lim;
      lim = (longint'(1) <<< (w - 1)) - 1;
      if (x > lim) return lim;
      if (x < -lim - 1) return -lim - 1;
      return x;
    endfunction

    // Turns in units of 2^32 per revolution, rounded half up on the magnitude.
    function logic [31:0] angle_of(logic signed [55:0] p, logic signed [31:0] f);
      logic [55:0] pm;
      logic [31:0] fm, ang;
      logic [87:0] prod, quo, rem;
      bit          neg;
      neg  = (p < 0) != (f < 0);
      pm   = p[55] ? (~p + 56'd1) : p;
      fm   = f[31] ? (~f + 32'd1) : f;
      prod = {32'b0, pm} * {56'b0, fm};
      quo  = prod / 88'(FACTOR_DIV);
      rem  = prod % 88'(FACTOR_DIV);
      ang  = quo[31:0] + (((rem << 1) >= 88'(FACTOR_DIV)) ? 32'd1 : 32'd0);
      if (neg) ang = -ang;
      return ang;
    endfunction

    function void phasor_of(logic [31:0] ang, output longint c, output longint s);
      longint atan_steps[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                 333772, 166886, 83443, 41722, 20861, 10430, 5215};
      logic [31:0] a;
      longint x, y, z, dx, dy, cc, ss;
      a = ang + 32'h2000_0000;
      z = longint'({2'b0, a[29:0]}) - 64'sd536870912;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 18; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_steps[i];
        end else begin
          x += dx; y -= dy; z += atan_steps[i];
        end
      end
      cc = (x + 8192) >>> 14;
      ss = (y + 8192) >>> 14;
      if (cc > 131071) cc = 131071;
      if (cc < -131071) cc = -131071;
      if (ss > 131071) ss = 131071;
      if (ss < -131071) ss = -131071;
      case (a[31:30])
        2'd0: begin c = cc;  s = ss;  end
        2'd1: begin c = -ss; s = cc;  end
        2'd2: begin c = -cc; s = -ss; end
        default: begin c = ss; s = -cc; end
      endcase
    endfunction

    function void note_beat(beat_t b);
      result_t r;
      longint  acc, ph, pc, ps, re, im;
      longint  crd[3];
      r = '{default: '0};
      case (b.op)
        OP_LOAD_COEF: begin
          if (b.idx < 12) coefs[b.idx] = b.val[19:0];
        end
        OP_LOAD_FACTOR: factors[b.ch] = b.val;
        OP_BASELINE: begin
          crd[0] = b.u; crd[1] = b.v; crd[2] = b.w;
          r.kind = KIND_UVW;
          for (int row = 0; row < 3; row++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += longint'(coefs[3*row+k]) * crd[k];
            acc = sat((acc + 65536) >>> 17, 32);
            if (row == 0) r.u = 32'(acc);
            else if (row == 1) r.v = 32'(acc);
            else r.w = 32'(acc);
          end
          ph = 0;
          for (int k = 0; k < 3; k++) ph += longint'(coefs[9+k]) * crd[k];
          bl_phase = 56'(sat(ph, 56));
          pending_results = {pending_results, r};
        end
        default: begin
          phasor_of(angle_of(bl_phase, factors[b.ch]), pc, ps);
          re = longint'(b.re) * pc - longint'(b.im) * ps;
          im = longint'(b.re) * ps + longint'(b.im) * pc;
          r.kind = KIND_VIS;
          r.re   = 24'(sat((re + 32768) >>> 16, 24));
          r.im   = 24'(sat((im + 32768) >>> 16, 24));
          pending_results = {pending_results, r};
        end
      endcase
    endfunction

    function void check_beat(result_t got);
      result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d u=%0d v=%0d w=%0d re=%0d im=%0d", $time,
                 got.kind, got.u, got.v, got.w, got.re, got.im);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.kind !== e.kind || got.u !== e.u || got.v !== e.v || got.w !== e.w ||
          got.re !== e.re || got.im !== e.im) begin
        $display("%0t: mismatch expected kind=%0d u=%0d v=%0d w=%0d re=%0d im=%0d", $time,
                 e.kind, e.u, e.v, e.w, e.re, e.im);
        $display("%0t:          actual   kind=%0d u=%0d v=%0d w=%0d re=%0d im=%0d", $time,
                 got.kind, got.u, got.v, got.w, got.re, got.im);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         op = '0;
  logic signed [31:0] u_in = '0, v_in = '0, w_in = '0;
  logic [9:0]         channel = '0;
  logic signed [23:0] sample_re = '0, sample_im = '0;
  logic [3:0]         coef_index = '0;
  logic signed [31:0] load_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic signed [31:0] u_out, v_out, w_out;
  logic signed [23:0] out_re, out_im;

  rotator_scoreboard sb = new();
  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  int                hold_cycles = 0;
  int                cycles = 0;
  int                loaded_chans[$];

  visibility_phase_rotator_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .u_in(u_in), .v_in(v_in), .w_in(w_in), .channel(channel),
    .sample_re(sample_re), .sample_im(sample_im), .coef_index(coef_index),
    .load_value(load_value), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .u_out(u_out), .v_out(v_out), .w_out(w_out),
    .out_re(out_re), .out_im(out_im)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    beat_t   b;
    result_t r;
    if (!rst && in_valid && in_ready) begin
      b.op = op_t'(op); b.u = u_in; b.v = v_in; b.w = w_in; b.ch = channel;
      b.re = sample_re; b.im = sample_im; b.idx = coef_index; b.val = load_value;
      sb.note_beat(b);
    end
    if (!rst && out_valid && out_ready) begin
      r.kind = kind; r.u = u_out; r.v = v_out; r.w = w_out; r.re = out_re; r.im = out_im;
      sb.check_beat(r);
    end
  end

  // A long hold-off is counted here so the sender keeps pushing while the output backs up.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_beat(beat_t b);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    op = b.op; u_in = b.u; v_in = b.v; w_in = b.w; channel = b.ch;
    sample_re = b.re; sample_im = b.im; coef_index = b.idx; load_value = b.val;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic beat_t rand_beat(op_t o);
    beat_t b;
    b.op = o;
    b.u = $urandom; b.v = $urandom; b.w = $urandom;
    if ($urandom_range(3) == 0) begin
      b.u = $signed($urandom_range(20000)) - 10000;
      b.v = $signed($urandom_range(20000)) - 10000;
      b.w = $signed($urandom_range(20000)) - 10000;
    end
    b.ch = 10'($urandom);
    b.re = 24'($urandom); b.im = 24'($urandom);
    b.idx = 4'($urandom_range(11));
    b.val = $urandom;
    return b;
  endfunction

  task automatic load_factor(int ch, logic signed [31:0] val);
    beat_t b;
    b = rand_beat(OP_LOAD_FACTOR);
    b.ch = 10'(ch); b.val = val;
    send_beat(b);
    loaded_chans = {loaded_chans, ch};
  endtask

  task automatic send_sample(logic signed [23:0] re, logic signed [23:0] im);
    beat_t b;
    b = rand_beat(OP_SAMPLE);
    b.ch = 10'(loaded_chans[$urandom_range(loaded_chans.size() - 1)]);
    b.re = re; b.im = im;
    send_beat(b);
  endtask

  task automatic send_baseline(logic signed [31:0] u, v, w);
    beat_t b;
    b = rand_beat(OP_BASELINE);
    b.u = u; b.v = v; b.w = w;
    send_beat(b);
  endtask

  task automatic load_coef(logic [3:0] idx, logic signed [31:0] val);
    beat_t b;
    b = rand_beat(OP_LOAD_COEF);
    b.idx = idx; b.val = val;
    send_beat(b);
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int n);
    int    sent;
    int    r;
    beat_t b;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        b = rand_beat(OP_BASELINE);
        send_beat(b);
        sent++;
        repeat ($urandom_range(5)) begin
          b = rand_beat(OP_SAMPLE);
          b.ch = 10'(loaded_chans[$urandom_range(loaded_chans.size() - 1)]);
          send_beat(b);
          sent++;
        end
      end else if (r < 78) begin
        b = rand_beat(OP_SAMPLE);
        b.ch = 10'(loaded_chans[$urandom_range(loaded_chans.size() - 1)]);
        send_beat(b);
        sent++;
      end else if (r < 89) begin
        b = rand_beat(OP_LOAD_COEF);
        b.idx = 4'($urandom_range(15));
        send_beat(b);
        if (b.idx < 12) sent++;
      end else begin
        b = rand_beat(OP_LOAD_FACTOR);
        send_beat(b);
        loaded_chans = {loaded_chans, int'(b.ch)};
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A sample before any baseline sees the reset phase of zero.
    load_factor(0, 32'sh0123_4567);
    send_sample(24'sh7FFFFF, 24'sh800000);
    load_factor(1023, 32'sh7FFF_FFFF);
    load_factor(512, 32'sh8000_0000);
    for (int i = 0; i < 12; i++) load_coef(4'(i), (i % 2) ? 32'hFFF7_FFFF : 32'h0007_FFFF);
    load_coef(4'd12, 32'h0);
    load_coef(4'd15, 32'h0);
    // Saturating coordinates on both sides.
    send_baseline(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_sample(24'sh800000, 24'sh800000);
    send_baseline(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF);
    send_baseline(0, 0, 0);
    send_sample(24'sh000001, -24'sh000001);
    for (int i = 0; i < 12; i++) load_coef(4'(i), $urandom);
    wait_drained();

    tx_idle_pct = 0; rx_stall_pct = 0;
    hold_cycles = 600;
    run_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 69; rx_stall_pct = 0;
    run_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 0; rx_stall_pct = 69;
    run_random(PHASE_ITEMS);
    wait_drained();

    tx_idle_pct = 8; rx_stall_pct = 8;
    run_random(PHASE_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
